// ----- hw/rtl/cifq_pkg.sv -----
// ----------------------------------------------------------------------------
// cifq_pkg: shared types and constants for the CAN acceptance filter queue
// Transfer payloads, status codes, operation codes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cifq_pkg;

  localparam int unsigned IdWidth   = 29;
  localparam int unsigned DlcWidth  = 4;
  localparam int unsigned DataWidth = 64;

  // Defaults for the top-level parameters
  localparam int unsigned IdTableSizeDef = 16;
  localparam int unsigned QueueDepthDef  = 16;

  // Operation codes carried in the func field
  localparam logic [1:0] FuncReg  = 2'd0;
  localparam logic [1:0] FuncFeed = 2'd1;
  localparam logic [1:0] FuncPop  = 2'd2;

  typedef enum logic [2:0] {
    StDone       = 3'd0,
    StDuplicate  = 3'd1,
    StTableFull  = 3'd2,
    StNoMatch    = 3'd3,
    StQueueFull  = 3'd4,
    StQueueEmpty = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmSearch,
    FsmRead,
    FsmEmit
  } fsm_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [IdWidth-1:0]   ident;
    logic                 frame_ext;
    logic [DlcWidth-1:0]  frame_dlc;
    logic [DataWidth-1:0] frame_data;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [IdWidth-1:0]   out_ident;
    logic                 out_ext;
    logic [DlcWidth-1:0]  out_dlc;
    logic [DataWidth-1:0] out_data;
  } out_t;

  // One queued frame
  typedef struct packed {
    logic                 ext;
    logic [IdWidth-1:0]   ident;
    logic [DlcWidth-1:0]  dlc;
    logic [DataWidth-1:0] data;
  } frame_t;

  // Lookup probe travelling down the cell chain
  typedef struct packed {
    logic               vld;
    logic [IdWidth-1:0] id;
    logic               hit;
  } probe_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cifq_cell.sv -----
// ----------------------------------------------------------------------------
// cifq_cell: one acceptance table entry in the lookup chain
// Holds one identifier and passes the lookup probe to its neighbor each cycle,
// folding in its own compare result.
// ----------------------------------------------------------------------------
`default_nettype none

module cifq_cell
  import cifq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               live_i,
  input  wire logic               wr_en_i,
  input  wire logic [IdWidth-1:0] wr_id_i,
  input  wire probe_t             probe_i,
  output probe_t                  probe_o
);

  logic [IdWidth-1:0] entry_q;
  probe_t             probe_d, probe_q;

  // Store the registered identifier
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_id_i;
    end
  end

  // Fold in the local compare
  always_comb begin
    probe_d     = probe_i;
    probe_d.hit = probe_i.hit | (live_i & (entry_q == probe_i.id));
  end

  // Advance the probe one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cifq_ring.sv -----
// ----------------------------------------------------------------------------
// cifq_ring: frame ring buffer
// Ring of Depth slots that keeps one slot empty; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cifq_ring
  import cifq_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ring_req_t req_i,
  input  wire frame_t    wr_frame_i,
  output ring_stat_t     stat_o,
  output frame_t         rd_frame_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  frame_t            mem [Depth];
  frame_t            rd_frame_q;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]   wr_nxt, rd_nxt;

  // Wrap pointers at the last slot
  assign wr_nxt = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_nxt = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  assign stat_o.empty = (wr_ptr_q == rd_ptr_q);
  assign stat_o.full  = (wr_nxt == rd_ptr_q);

  always_comb begin
    wr_ptr_d = req_i.push ? wr_nxt : wr_ptr_q;
    rd_ptr_d = req_i.pop  ? rd_nxt : rd_ptr_q;
  end

  // Write and read the slot memory
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wr_ptr_q] <= wr_frame_i;
    end
    if (req_i.pop) begin
      rd_frame_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  assign rd_frame_o = rd_frame_q;

endmodule

`default_nettype wire

// ----- hw/rtl/can_id_filter_rx_queue.sv -----
// ----------------------------------------------------------------------------
// can_id_filter_rx_queue: CAN receive acceptance filter with frame queue
// Register and feed send the lookup probe into the cell chain, which it walks one
// entry per cycle; the result is decided when the probe leaves the chain. Pop goes
// through one registered ring read; unused codes and empty pops go straight to the
// emit state. One operation is in flight at a time.
// Reset clears the table count, ring pointers and control; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_filter_rx_queue
  import cifq_pkg::*;
#(
  parameter int unsigned IdTableSize = IdTableSizeDef,
  parameter int unsigned QueueDepth  = QueueDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned CntW = $clog2(IdTableSize + 1);

  fsm_e            state_q, state_d;
  in_t             op_q, op_d;
  logic [CntW-1:0] id_count_q, id_count_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic            accept;
  logic            tbl_wr;
  probe_t          chain [IdTableSize+1];
  probe_t          chain_out;
  ring_req_t       ring_req;
  ring_stat_t      ring_stat;
  frame_t          ring_wr_frame;
  frame_t          ring_rd_frame;

  assign in_stall_o = (state_q != FsmIdle);
  assign accept     = in_valid_i & ~in_stall_o;

  // Launch a probe into the first cell on register and feed transfers
  always_comb begin
    chain[0].vld = accept & ((in_data_i.func == FuncReg) | (in_data_i.func == FuncFeed));
    chain[0].id  = in_data_i.ident;
    chain[0].hit = 1'b0;
  end

  // Acceptance table chain
  for (genvar i = 0; i < IdTableSize; i++) begin : g_cell
    cifq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .live_i  (id_count_q > CntW'(i)),
      .wr_en_i (tbl_wr & (id_count_q == CntW'(i))),
      .wr_id_i (op_q.ident),
      .probe_i (chain[i]),
      .probe_o (chain[i+1])
    );
  end

  assign chain_out = chain[IdTableSize];

  // Frame queue
  always_comb begin
    ring_wr_frame.ext   = op_q.frame_ext;
    ring_wr_frame.ident = op_q.ident;
    ring_wr_frame.dlc   = op_q.frame_dlc;
    ring_wr_frame.data  = op_q.frame_data;
  end

  cifq_ring #(
    .Depth (QueueDepth)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ring_req),
    .wr_frame_i (ring_wr_frame),
    .stat_o     (ring_stat),
    .rd_frame_o (ring_rd_frame)
  );

  // Sequence one operation and hand its result to the output register
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_count_d = id_count_q;
    res_d      = res_q;
    tbl_wr     = 1'b0;
    ring_req   = '0;
    out_d      = out_q;
    out_vld_d  = out_vld_q & out_stall_i;

    unique case (state_q)
      FsmIdle: begin
        if (accept) begin
          op_d  = in_data_i;
          res_d = '0;
          unique case (in_data_i.func)
            FuncReg, FuncFeed: begin
              state_d = FsmSearch;
            end
            FuncPop: begin
              if (ring_stat.empty) begin
                res_d.status = StQueueEmpty;
                state_d      = FsmEmit;
              end else begin
                ring_req.pop = 1'b1;
                state_d      = FsmRead;
              end
            end
            default: begin
              res_d.status = StDone;
              state_d      = FsmEmit;
            end
          endcase
        end
      end
      FsmSearch: begin
        if (chain_out.vld) begin
          res_d   = '0;
          state_d = FsmEmit;
          unique case (op_q.func)
            FuncReg: begin
              if (chain_out.hit) begin
                res_d.status = StDuplicate;
              end else if (id_count_q == CntW'(IdTableSize)) begin
                res_d.status = StTableFull;
              end else begin
                tbl_wr       = 1'b1;
                id_count_d   = id_count_q + 1'b1;
                res_d.status = StDone;
              end
            end
            FuncFeed: begin
              if (!chain_out.hit) begin
                res_d.status = StNoMatch;
              end else if (ring_stat.full) begin
                res_d.status = StQueueFull;
              end else begin
                ring_req.push = 1'b1;
                res_d.status  = StDone;
              end
            end
            default: begin
              res_d.status = StDone;
            end
          endcase
        end
      end
      FsmRead: begin
        res_d.status    = StDone;
        res_d.out_ident = ring_rd_frame.ident;
        res_d.out_ext   = ring_rd_frame.ext;
        res_d.out_dlc   = ring_rd_frame.dlc;
        res_d.out_data  = ring_rd_frame.data;
        state_d         = FsmEmit;
      end
      FsmEmit: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = FsmIdle;
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FsmIdle;
      id_count_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      id_count_q <= id_count_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Stall input right after a transfer until the operation completes
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // Probe leaves the chain only while a lookup is pending
  a_probe_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.vld |-> (state_q == FsmSearch))
    else $error("probe left chain outside search");

  // Table count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_count_q <= CntW'(IdTableSize))
    else $error("table count overflow");

  // Ring is never popped empty nor pushed full
  a_ring_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_req.pop |-> !ring_stat.empty) and (ring_req.push |-> !ring_stat.full))
    else $error("ring access violates fill state");

  // Output register is loaded only from the emit state
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == FsmEmit))
    else $error("result loaded outside emit");

endmodule

`default_nettype wire
